FILE: rtl/gamepad_typematic_repeat_defines.svh
// Assertion macros shared by the checker. Clock clk_i, reset rst_ni.
`ifndef GAMEPAD_TYPEMATIC_REPEAT_DEFINES_SVH
`define GAMEPAD_TYPEMATIC_REPEAT_DEFINES_SVH

// Checked only while out of reset.
`define GTR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define GTR_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/gtr_pkg.sv
package gtr_pkg;

  localparam int NUM_REPEAT_BUTTONS_DEF = 12;
  localparam int NUM_BUTTONS_DEF        = 14;

  localparam logic [15:0] DELAY_RESET  = 16'd250;
  localparam logic [14:0] THRESH_RESET = 15'd8192;

  // register index, taken from paddr[2]
  localparam logic REG_DELAY  = 1'b0;
  localparam logic REG_THRESH = 1'b1;

  localparam logic [2:0] EV_LEFT_TRIGGER  = 3'd4;
  localparam logic [2:0] EV_RIGHT_TRIGGER = 3'd5;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_DIGITAL = 2'd0,
    ACT_AXIS    = 2'd1,
    ACT_TRIGGER = 2'd2,
    ACT_TICK    = 2'd3
  } action_e;

  // Classified item: a tick, or up to two button updates applied in order.
  typedef struct packed {
    logic       is_tick;
    logic       en0;
    logic [3:0] btn0;
    logic       down0;
    logic       en1;
    logic [3:0] btn1;
    logic       down1;
  } cmd_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] code;
    logic [3:0] btn;
    logic       rep;
  } event_t;

  typedef struct packed {
    event_t ev;
    logic   any;
    logic   last;
  } result_t;

  // Event of a button; valid low where the button has no event code.
  function automatic event_t button_event(logic [3:0] b, int nrb, logic rep);
    event_t     e;
    logic [4:0] b5;
    e  = '0;
    b5 = {1'b0, b};
    if (b5 < 5'(nrb)) begin
      e.valid = 1'b1;
      e.code  = {1'b0, b[1:0]};
    end else if (b5 == 5'(nrb)) begin
      e.valid = 1'b1;
      e.code  = EV_LEFT_TRIGGER;
    end else if (b5 == 5'(nrb + 1)) begin
      e.valid = 1'b1;
      e.code  = EV_RIGHT_TRIGGER;
    end
    if (e.valid) begin
      e.btn = b;
      e.rep = rep;
    end
    return e;
  endfunction

endpackage

FILE: rtl/gamepad_typematic_repeat.sv
// Channel   Direction  Handshake                 Beat
// config    in/out     psel/penable/pwrite       one register write or read (pready high)
// in        in         in_valid_i / in_stall_o   action, button_index, pressed, analog_value
// out       out        out_valid_o / out_stall_i one result; last marks the item's final one
//
// The front takes one beat a cycle into a two-entry command queue until it fills.
// Button, axis and trigger items each give one result from the back while the output is free.
// For a tick the back visits one countdown a cycle while a second event has room.
// A stalled output holds the back; the queue then fills and stalls the input.
// Reset clears the held buttons and restores both registers; countdowns load on press.
module gamepad_typematic_repeat #(
  parameter int NUM_REPEAT_BUTTONS = gtr_pkg::NUM_REPEAT_BUTTONS_DEF,
  parameter int NUM_BUTTONS        = gtr_pkg::NUM_BUTTONS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic [3:0]         button_index_i,
  input  logic               pressed_i,
  input  logic signed [15:0] analog_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               event_valid_o,
  output logic [2:0]         event_code_o,
  output logic [3:0]         source_button_o,
  output logic               is_repeat_o,
  output logic               any_held_o,
  output logic               last_o
);
  import gtr_pkg::*;

  logic        push, full, pop, q_valid;
  cmd_t        cmd_in, cmd_out;
  logic [15:0] delay;
  result_t     res;

  assign pready = 1'b1;

  gtr_front #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .button_index_i (button_index_i),
    .pressed_i      (pressed_i),
    .analog_value_i (analog_value_i),
    .queue_full_i   (full),
    .push_o         (push),
    .cmd_o          (cmd_in),
    .delay_o        (delay)
  );

  gtr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (cmd_out)
  );

  gtr_back #(
    .NUM_REPEAT_BUTTONS (NUM_REPEAT_BUTTONS),
    .NUM_BUTTONS        (NUM_BUTTONS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (cmd_out),
    .pop_o       (pop),
    .delay_i     (delay),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (res)
  );

  assign event_valid_o   = res.ev.valid;
  assign event_code_o    = res.ev.code;
  assign source_button_o = res.ev.btn;
  assign is_repeat_o     = res.ev.rep;
  assign any_held_o      = res.any;
  assign last_o          = res.last;

endmodule

FILE: rtl/gtr_queue.sv
module gtr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  gtr_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output gtr_pkg::cmd_t cmd_o
);
  import gtr_pkg::*;

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

FILE: rtl/gtr_front.sv
module gtr_front #(
  parameter int NUM_BUTTONS = gtr_pkg::NUM_BUTTONS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic [3:0]         button_index_i,
  input  logic               pressed_i,
  input  logic signed [15:0] analog_value_i,
  input  logic               queue_full_i,
  output logic               push_o,
  output gtr_pkg::cmd_t      cmd_o,
  output logic [15:0]        delay_o
);
  import gtr_pkg::*;

  logic [15:0]        delay_q;
  logic [14:0]        thresh_q;
  logic               wr_en;
  logic signed [16:0] val_x, thr_x, nthr_x;
  logic               below, above;
  logic [4:0]         idx5, idx5_next;
  logic               idx_ok, pair_ok;

  assign wr_en   = psel && penable && pwrite;
  assign prdata  = (paddr[2] == REG_THRESH) ? {17'd0, thresh_q} : {16'd0, delay_q};
  assign delay_o = delay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q  <= DELAY_RESET;
      thresh_q <= THRESH_RESET;
    end else if (wr_en) begin
      if (paddr[2] == REG_THRESH) begin
        thresh_q <= pwdata[14:0];
      end else begin
        delay_q <= pwdata[15:0];
      end
    end
  end

  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

  assign val_x     = {analog_value_i[15], analog_value_i};
  assign thr_x     = $signed({2'b00, thresh_q});
  assign nthr_x    = -thr_x;
  assign below     = val_x < nthr_x;
  assign above     = val_x > thr_x;
  assign idx5      = {1'b0, button_index_i};
  assign idx5_next = idx5 + 5'd1;
  assign idx_ok    = idx5 < 5'(NUM_BUTTONS);
  assign pair_ok   = !button_index_i[0] && (idx5_next < 5'(NUM_BUTTONS));

  always_comb begin
    cmd_o      = '0;
    cmd_o.btn0 = button_index_i;
    cmd_o.btn1 = idx5_next[3:0];
    unique case (action_e'(action_i))
      ACT_DIGITAL: begin
        cmd_o.en0   = idx_ok;
        cmd_o.down0 = pressed_i;
      end
      ACT_AXIS: begin
        // negative button first, then the positive one
        cmd_o.en0   = pair_ok;
        cmd_o.down0 = below;
        cmd_o.en1   = pair_ok;
        cmd_o.down1 = above;
      end
      ACT_TRIGGER: begin
        cmd_o.en0   = idx_ok;
        cmd_o.down0 = above;
      end
      ACT_TICK: begin
        cmd_o.is_tick = 1'b1;
      end
      default: begin
        cmd_o.is_tick = 1'b1;
      end
    endcase
  end

endmodule

FILE: rtl/gtr_back.sv
module gtr_back #(
  parameter int NUM_REPEAT_BUTTONS = gtr_pkg::NUM_REPEAT_BUTTONS_DEF,
  parameter int NUM_BUTTONS        = gtr_pkg::NUM_BUTTONS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  gtr_pkg::cmd_t    cmd_i,
  output logic             pop_o,
  input  logic [15:0]      delay_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output gtr_pkg::result_t out_o
);
  import gtr_pkg::*;

  localparam int IDX_W = (NUM_REPEAT_BUTTONS > 1) ? $clog2(NUM_REPEAT_BUTTONS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_REPEAT_BUTTONS - 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_e;

  state_e               state_q, state_d;
  logic [IDX_W-1:0]     scan_q, scan_d;
  logic [NUM_BUTTONS-1:0] held_q, held_d;
  logic [15:0]          cnt_q [NUM_REPEAT_BUTTONS];
  event_t               pend_q, pend_d;
  logic                 pend_valid_q, pend_valid_d;
  logic                 any_q, any_d;
  result_t              out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  logic                 out_free;
  logic [15:0]          held16, m1, m2;
  logic                 fire0, fire1, fired;
  logic [3:0]           fire_btn;
  event_t               set_ev;
  logic [3:0]           scan_btn;
  logic [15:0]          cnt_rd;
  logic                 scan_held, scan_fire;
  logic                 cnt_we;
  logic [IDX_W-1:0]     cnt_wa;
  logic [15:0]          cnt_wd;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Press path: apply both updates in order, at most one can fire.
  always_comb begin
    held16 = 16'(held_q);
    fire0  = cmd_i.en0 && cmd_i.down0 && !held16[cmd_i.btn0];
    m1     = held16;
    if (cmd_i.en0) begin
      m1[cmd_i.btn0] = cmd_i.down0;
    end
    fire1 = cmd_i.en1 && cmd_i.down1 && !m1[cmd_i.btn1];
    m2    = m1;
    if (cmd_i.en1) begin
      m2[cmd_i.btn1] = cmd_i.down1;
    end
    fired    = fire0 || fire1;
    fire_btn = fire0 ? cmd_i.btn0 : cmd_i.btn1;
    set_ev   = button_event(fire_btn, NUM_REPEAT_BUTTONS, 1'b0);
    if (!fired) begin
      set_ev = '0;
    end
  end

  assign scan_btn  = 4'(scan_q);
  assign cnt_rd    = cnt_q[scan_q];
  assign scan_held = held16[scan_btn];
  assign scan_fire = scan_held && (cnt_rd < 16'd2);

  always_comb begin
    state_d      = state_q;
    scan_d       = scan_q;
    held_d       = held_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    any_d        = any_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;
    pop_o        = 1'b0;
    cnt_we       = 1'b0;
    cnt_wa       = scan_q;
    cnt_wd       = cnt_rd - 16'd1;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.is_tick) begin
            pop_o        = 1'b1;
            any_d        = |held_q;
            scan_d       = '0;
            pend_valid_d = 1'b0;
            state_d      = ST_SCAN;
          end else if (out_free) begin
            pop_o       = 1'b1;
            held_d      = m2[NUM_BUTTONS-1:0];
            out_valid_d = 1'b1;
            out_d.ev    = set_ev;
            out_d.any   = |m2[NUM_BUTTONS-1:0];
            out_d.last  = 1'b1;
            if (fired && ({1'b0, fire_btn} < 5'(NUM_REPEAT_BUTTONS))) begin
              cnt_we = 1'b1;
              cnt_wa = fire_btn[IDX_W-1:0];
              cnt_wd = delay_i;
            end
          end
        end
      end
      ST_SCAN: begin
        // hold the scan while a second event finds no room
        if (!(scan_fire && pend_valid_q && !out_free)) begin
          if (scan_held) begin
            cnt_we = 1'b1;
            cnt_wd = scan_fire ? delay_i : cnt_rd - 16'd1;
          end
          if (scan_fire) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_d.ev    = pend_q;
              out_d.any   = any_q;
              out_d.last  = 1'b0;
            end
            pend_d       = button_event(scan_btn, NUM_REPEAT_BUTTONS, 1'b1);
            pend_valid_d = 1'b1;
          end
          if (scan_q == LAST_IDX) begin
            state_d = ST_FLUSH;
          end else begin
            scan_d = scan_q + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_d.ev     = pend_valid_q ? pend_q : '0;
          out_d.any    = any_q;
          out_d.last   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      scan_q       <= '0;
      held_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      scan_q       <= scan_d;
      held_q       <= held_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    any_q  <= any_d;
    out_q  <= out_d;
    if (cnt_we) begin
      cnt_q[cnt_wa] <= cnt_wd;
    end
  end

endmodule

FILE: rtl/gtr_checker.sv
`include "gamepad_typematic_repeat_defines.svh"

module gtr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       event_valid_o,
  input logic [2:0] event_code_o,
  input logic [3:0] source_button_o,
  input logic       is_repeat_o,
  input logic       last_o
);

  `GTR_ASSERT_ALWAYS(a_reset_no_result, !rst_ni |-> !out_valid_o, "result beat during reset")

  `GTR_ASSERT(a_stall_holds, out_valid_o && out_stall_i |=> out_valid_o && $stable(event_code_o) && $stable(source_button_o) && $stable(last_o), "stalled result changed")

  `GTR_ASSERT(a_empty_result, out_valid_o && !event_valid_o |-> last_o && event_code_o == 3'd0 && source_button_o == 4'd0 && !is_repeat_o, "empty result not clean or not final")

  `GTR_ASSERT(a_repeat_code, out_valid_o && event_valid_o && is_repeat_o |-> event_code_o[2] == 1'b0 && event_code_o[1:0] == source_button_o[1:0], "repeat event with a trigger code")

endmodule

bind gamepad_typematic_repeat gtr_checker u_gtr_checker (.*);
